@@ src/elufs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the exec line unescape and field strip block.
package elufs_pkg;

	localparam int IN_MAX_DEF = 4095;
	localparam int PKT_DEPTH = 4;
	localparam int RES_DEPTH = 4;

	localparam int LIMIT_W = 13;
	localparam int SPACE_W = 12;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RST = 13'd4096;
	localparam logic [SPACE_W-1:0] SPACE_MAX = 12'hFFF;

	localparam logic [PADDR_W-3:0] REG_OUT_LIMIT = 1'b0;

	localparam logic [7:0] CH_PCT = 8'h25;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_S = 8'h73;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_DQ = 8'h22;
	localparam logic [7:0] CH_SQ = 8'h27;

	// up to two unescaped bytes plus the end-of-string mark from one input beat
	typedef struct packed {
		logic [7:0] b0;
		logic       v0;
		logic [7:0] b1;
		logic       v1;
		logic       last;
	} pkt_t;

	typedef struct packed {
		logic [SPACE_W-1:0] space_run;
		logic [7:0]         out_char;
		logic               char_valid;
		logic               out_last;
	} res_t;

endpackage

@@ src/elufs_fifo.sv @@
`timescale 1ns / 1ps
// Small first-word-fall-through queue built from registers.
module elufs_fifo #(
	parameter int W = 8,
	parameter int DEPTH = elufs_pkg::PKT_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

@@ src/elufs_front.sv @@
`timescale 1ns / 1ps
// Front stage: takes raw bytes, undoes escapes and packs the unescaped bytes.
module elufs_front #(
	parameter int IN_MAX = elufs_pkg::IN_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic              q_full,
	output elufs_pkg::pkt_t   pkt,
	output logic              pkt_push
);

	localparam int InW = $clog2(IN_MAX + 1);

	logic           esc_q;
	logic [InW-1:0] in_cnt_q;
	logic           accept;
	logic           take;
	logic           esc_after;

	assign accept = push && !q_full;
	assign take   = (in_byte != 8'h00) && (in_cnt_q < InW'(IN_MAX));

	always_comb begin
		pkt       = '0;
		esc_after = esc_q;
		if (take) begin
			if (esc_q) begin
				esc_after = 1'b0;
				pkt.v0    = 1'b1;
				unique case (in_byte)
					elufs_pkg::CH_S:   pkt.b0 = elufs_pkg::CH_SP;
					elufs_pkg::CH_N:   pkt.b0 = elufs_pkg::CH_NL;
					elufs_pkg::CH_T:   pkt.b0 = elufs_pkg::CH_TAB;
					elufs_pkg::CH_R:   pkt.b0 = elufs_pkg::CH_CR;
					elufs_pkg::CH_BSL: pkt.b0 = elufs_pkg::CH_BSL;
					default: begin
						pkt.b0 = elufs_pkg::CH_BSL;
						pkt.b1 = in_byte;
						pkt.v1 = 1'b1;
					end
				endcase
			end else if (in_byte == elufs_pkg::CH_BSL) begin
				esc_after = 1'b1;
			end else begin
				pkt.b0 = in_byte;
				pkt.v0 = 1'b1;
			end
		end
		// lone trailing backslash stays; no bytes were produced in that case
		if (in_last && esc_after) begin
			pkt.b0 = elufs_pkg::CH_BSL;
			pkt.v0 = 1'b1;
		end
		pkt.last = in_last;
	end

	assign pkt_push = accept && (pkt.v0 || pkt.v1 || pkt.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q    <= 1'b0;
			in_cnt_q <= '0;
		end else if (accept) begin
			if (in_last) begin
				esc_q    <= 1'b0;
				in_cnt_q <= '0;
			end else begin
				esc_q <= esc_after;
				if (take) begin
					in_cnt_q <= in_cnt_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ src/elufs_back.sv @@
`timescale 1ns / 1ps
// Back stage: four-byte lookahead, field code removal, space runs and limit.
module elufs_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [elufs_pkg::LIMIT_W-1:0]      out_limit,
	input  elufs_pkg::pkt_t                    pkt,
	input  logic                               pkt_valid,
	output logic                               pkt_pop,
	input  logic                               res_full,
	output elufs_pkg::res_t                    res,
	output logic                               res_push
);

	logic [7:0]                    la_q [4];
	logic [7:0]                    la_n [4];
	logic [2:0]                    cnt_q, cnt_n;
	logic [elufs_pkg::SPACE_W-1:0] pend_q, pend_n;
	logic [7:0]                    held_q, held_n;
	logic                          held_v_q, held_v_n;
	logic                          qgap_q, qgap_n;
	logic [elufs_pkg::LIMIT_W-1:0] ocnt_q, ocnt_n;
	logic                          full_q, full_n;
	logic [1:0]                    ptr_q, ptr_n;

	logic       go;
	logic       has0, has1, end_tok, proc;
	logic       do_emit, do_shift;
	logic [1:0] shift_k;
	logic [7:0] emit_c;
	logic [2:0] j;

	assign go      = !res_full;
	assign has0    = (ptr_q == 2'd0) && pkt.v0;
	assign has1    = (ptr_q != 2'd2) && pkt.v1;
	assign end_tok = pkt_valid && !has0 && !has1;
	assign proc    = go && ((cnt_q == 3'd4) || (end_tok && cnt_q != 3'd0));

	always_comb begin
		cnt_n    = cnt_q;
		pend_n   = pend_q;
		held_n   = held_q;
		held_v_n = held_v_q;
		qgap_n   = qgap_q;
		ocnt_n   = ocnt_q;
		full_n   = full_q;
		ptr_n    = ptr_q;
		pkt_pop  = 1'b0;
		res      = '0;
		res_push = 1'b0;
		do_emit  = 1'b0;
		do_shift = 1'b0;
		shift_k  = 2'd1;
		emit_c   = la_q[0];
		j        = 3'd0;
		for (int i = 0; i < 4; i++) begin
			la_n[i] = la_q[i];
		end

		if (proc) begin
			if ({1'b0, ocnt_q} + 14'd1 >= {1'b0, out_limit}) begin
				full_n = 1'b1;
				cnt_n  = 3'd0;
			end else if (la_q[0] == elufs_pkg::CH_PCT && cnt_q >= 3'd2) begin
				if (la_q[1] == elufs_pkg::CH_PCT) begin
					do_emit = 1'b1;
					emit_c  = elufs_pkg::CH_PCT;
					shift_k = 2'd2;
				end else if (cnt_q >= 3'd3 && held_v_q && qgap_q && la_q[2] == held_q &&
					(cnt_q == 3'd3 || la_q[3] == elufs_pkg::CH_SP)) begin
					// quoted field code alone: take the opening quote back
					held_v_n = 1'b0;
					qgap_n   = 1'b0;
					ocnt_n   = ocnt_q - 1'b1;
					do_shift = 1'b1;
					shift_k  = 2'd3;
				end else begin
					do_shift = 1'b1;
					shift_k  = 2'd2;
				end
			end else begin
				do_emit = 1'b1;
				shift_k = 2'd1;
			end

			if (do_emit) begin
				if (held_v_q) begin
					// flush the held quote first; the byte stays in the lookahead and goes after it
					res      = '{space_run: pend_q, out_char: held_q, char_valid: 1'b1,
						out_last: 1'b0};
					res_push = 1'b1;
					pend_n   = '0;
					held_v_n = 1'b0;
					qgap_n   = 1'b0;
				end else begin
					do_shift = 1'b1;
					ocnt_n   = ocnt_q + 1'b1;
					if (emit_c == elufs_pkg::CH_SP) begin
						if (pend_q != elufs_pkg::SPACE_MAX) begin
							pend_n = pend_q + 1'b1;
						end
					end else if (emit_c == elufs_pkg::CH_DQ || emit_c == elufs_pkg::CH_SQ) begin
						held_n   = emit_c;
						held_v_n = 1'b1;
						qgap_n   = (pend_q != '0) || (ocnt_q == '0);
					end else begin
						res      = '{space_run: pend_q, out_char: emit_c, char_valid: 1'b1,
							out_last: 1'b0};
						res_push = 1'b1;
						pend_n   = '0;
					end
				end
			end

			if (do_shift) begin
				cnt_n = cnt_q - {1'b0, shift_k};
				for (int i = 0; i < 4; i++) begin
					j = 3'(i) + {1'b0, shift_k};
					la_n[i] = (j < 3'd4) ? la_q[j[1:0]] : 8'h00;
				end
			end
		end else if (go && pkt_valid) begin
			if (has0 || has1) begin
				if (!full_q) begin
					la_n[cnt_q[1:0]] = has0 ? pkt.b0 : pkt.b1;
					cnt_n            = cnt_q + 3'd1;
				end
				if (has0) begin
					if (pkt.v1 || pkt.last) begin
						ptr_n = 2'd1;
					end else begin
						ptr_n   = 2'd0;
						pkt_pop = 1'b1;
					end
				end else if (pkt.last) begin
					ptr_n = 2'd2;
				end else begin
					ptr_n   = 2'd0;
					pkt_pop = 1'b1;
				end
			end else if (held_v_q) begin
				res      = '{space_run: pend_q, out_char: held_q, char_valid: 1'b1,
					out_last: 1'b0};
				res_push = 1'b1;
				pend_n   = '0;
				held_v_n = 1'b0;
				qgap_n   = 1'b0;
			end else begin
				res      = '{space_run: '0, out_char: 8'h00, char_valid: 1'b0,
					out_last: 1'b1};
				res_push = 1'b1;
				cnt_n    = 3'd0;
				pend_n   = '0;
				qgap_n   = 1'b0;
				ocnt_n   = '0;
				full_n   = 1'b0;
				ptr_n    = 2'd0;
				pkt_pop  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 3'd0;
			pend_q   <= '0;
			held_v_q <= 1'b0;
			qgap_q   <= 1'b0;
			ocnt_q   <= '0;
			full_q   <= 1'b0;
			ptr_q    <= 2'd0;
		end else begin
			cnt_q    <= cnt_n;
			pend_q   <= pend_n;
			held_v_q <= held_v_n;
			qgap_q   <= qgap_n;
			ocnt_q   <= ocnt_n;
			full_q   <= full_n;
			ptr_q    <= ptr_n;
		end
	end

	always_ff @(posedge clk) begin
		held_q <= held_n;
		for (int i = 0; i < 4; i++) begin
			la_q[i] <= la_n[i];
		end
	end

endmodule

@@ src/exec_line_unescape_field_strip_core.sv @@
`timescale 1ns / 1ps
// Top level: exec line unescape, field code strip, APB register and queues.
//
// Takes one raw byte per beat and returns results as a queue. The front stage
// takes a beat per cycle into a four-deep queue while that queue is not full.
// The back stage loads each unescaped byte into its lookahead and then processes
// it, and an escape that expands to two bytes is loaded and processed as two
// bytes. A byte emitted while a quote is held waits while the quote is sent
// first. A backslash that opens an escape or a zero byte adds no byte to the back
// stage. After its own bytes, a beat with in_last drains up to three lookahead
// bytes, each of which may flush a held quote first, then a last held quote and
// the closing result. The back stage stalls while the four-deep result queue is
// full. out_limit (byte address 0) is the output buffer size, reset 4096.
module exec_line_unescape_field_strip_core #(
	parameter int IN_MAX = elufs_pkg::IN_MAX_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [elufs_pkg::PADDR_W-1:0]      paddr,
	input  logic [elufs_pkg::PDATA_W-1:0]      pwdata,
	output logic [elufs_pkg::PDATA_W-1:0]      prdata,
	output logic                               pready,
	input  logic                               push,
	output logic                               full,
	input  logic [7:0]                         in_byte,
	input  logic                               in_last,
	output logic                               empty,
	input  logic                               pop,
	output logic [elufs_pkg::SPACE_W-1:0]      space_run,
	output logic [7:0]                         out_char,
	output logic                               char_valid,
	output logic                               out_last
);

	logic [elufs_pkg::LIMIT_W-1:0] out_limit_q;
	logic                          reg_sel;

	elufs_pkg::pkt_t pkt_w;
	elufs_pkg::pkt_t pkt_r;
	logic            pkt_push;
	logic            pkt_full;
	logic            pkt_empty;
	logic            pkt_pop;

	elufs_pkg::res_t res_w;
	elufs_pkg::res_t res_r;
	logic            res_push;
	logic            res_full;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[elufs_pkg::PADDR_W-1:2] == elufs_pkg::REG_OUT_LIMIT);
	assign prdata  = reg_sel ? elufs_pkg::PDATA_W'(out_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_limit_q <= elufs_pkg::LIMIT_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			out_limit_q <= pwdata[elufs_pkg::LIMIT_W-1:0];
		end
	end

	elufs_front #(
		.IN_MAX(IN_MAX)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.in_byte (in_byte),
		.in_last (in_last),
		.q_full  (pkt_full),
		.pkt     (pkt_w),
		.pkt_push(pkt_push)
	);

	assign full = pkt_full;

	elufs_fifo #(
		.W    ($bits(elufs_pkg::pkt_t)),
		.DEPTH(elufs_pkg::PKT_DEPTH)
	) u_pkt_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (pkt_push),
		.wdata (pkt_w),
		.full  (pkt_full),
		.pop   (pkt_pop),
		.rdata (pkt_r),
		.empty (pkt_empty)
	);

	elufs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.out_limit(out_limit_q),
		.pkt      (pkt_r),
		.pkt_valid(!pkt_empty),
		.pkt_pop  (pkt_pop),
		.res_full (res_full),
		.res      (res_w),
		.res_push (res_push)
	);

	elufs_fifo #(
		.W    ($bits(elufs_pkg::res_t)),
		.DEPTH(elufs_pkg::RES_DEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_w),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_r),
		.empty (empty)
	);

	assign space_run  = res_r.space_run;
	assign out_char   = res_r.out_char;
	assign char_valid = res_r.char_valid;
	assign out_last   = res_r.out_last;

	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result beat written into a full queue");

	a_pkt_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_pop |-> !pkt_empty)
		else $error("back stage popped an empty packet queue");

	a_close_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_last) |-> (!char_valid && space_run == '0 && out_char == 8'h00))
		else $error("closing beat carries data");

endmodule
